// ----- rtl/cable_wrap_azimuth_unwrap_assert.svh -----
// assertion macros for the cable wrap azimuth unwrapper
// no dependencies; compiled out when SYNTH is defined
`ifndef CABLE_WRAP_AZIMUTH_UNWRAP_ASSERT_SVH
`define CABLE_WRAP_AZIMUTH_UNWRAP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication under synchronous reset
`define CWA_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("cwa assertion failed");
// next-cycle implication under synchronous reset
`define CWA_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("cwa assertion failed");
`else
`define CWA_ASSERT_IMP(name, ck, rn, ante, cons)
`define CWA_ASSERT_NXT(name, ck, rn, ante, cons)
`endif

`endif

// ----- rtl/cwa_pkg.sv -----
// shared constants, types and register codes of the azimuth unwrapper
// no dependencies
package cwa_pkg;

  // angle scaling and search bound
  localparam int TURN_BITS = 16;
  localparam int MAX_WRAPS = 4;

  // field widths
  localparam int AZ_W      = 18;
  localparam int AZI_W     = 16;
  localparam int EL_W      = 16;
  localparam int AZM_W     = 16;
  localparam int ELM_W     = 15;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  // internal widths
  localparam int EB_W  = EL_W + 2;
  localparam int CUR_W = ((AZ_W + 1 > TURN_BITS) ? AZ_W + 1 : TURN_BITS)
                         + $clog2(MAX_WRAPS + 1) + 2;
  localparam int DW    = CUR_W + 2;
  localparam int K_W   = $clog2(MAX_WRAPS + 1);
  localparam int SEC_MUL = 360 / 3;
  localparam int PROD_W  = CUR_W + $clog2(SEC_MUL + 1) + 1;

  typedef logic signed [CUR_W-1:0]  az_t;
  typedef logic signed [DW-1:0]     az2_t;
  typedef logic signed [EB_W-1:0]   eb_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam az_t TURN    = az_t'(64'sd1 <<< TURN_BITS);
  localparam az_t OUT_MAX = az_t'((64'sd1 <<< (AZ_W - 1)) - 64'sd1);
  localparam az_t OUT_MIN = az_t'(-(64'sd1 <<< (AZ_W - 1)));
  localparam logic [K_W-1:0] MAX_K = K_W'(MAX_WRAPS);

  // register reset values
  localparam logic signed [AZ_W-1:0] AZ_LO_LIM_RST = AZ_W'(-49152);
  localparam logic signed [AZ_W-1:0] AZ_HI_LIM_RST = AZ_W'(49152);
  localparam logic [AZM_W-1:0]       AZ_MRG_RST    = '0;
  localparam logic signed [EL_W-1:0] EL_LO_LIM_RST = EL_W'(0);
  localparam logic signed [EL_W-1:0] EL_HI_LIM_RST = EL_W'(16384);
  localparam logic [ELM_W-1:0]       EL_MRG_RST    = '0;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AZ_LO_LIM = 3'd0,
    REG_AZ_HI_LIM = 3'd1,
    REG_AZ_LO_MRG = 3'd2,
    REG_AZ_HI_MRG = 3'd3,
    REG_EL_LO_LIM = 3'd4,
    REG_EL_HI_LIM = 3'd5,
    REG_EL_LO_MRG = 3'd6,
    REG_EL_HI_MRG = 3'd7
  } cfg_reg_t;

  // step unit verdict
  typedef struct packed {
    logic adv;
    az_t  cand;
  } step_res_t;

  // limit check flags
  typedef struct packed {
    logic in_lim;
    logic secure;
  } chk_res_t;

endpackage

// ----- rtl/cwa_if.sv -----
// request and result channel interfaces of the azimuth unwrapper
// depends on cwa_pkg
interface cwa_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [cwa_pkg::AZI_W-1:0]         az_in;
  logic signed [cwa_pkg::EL_W-1:0]   el_in;
  logic signed [cwa_pkg::AZ_W-1:0]   ref_az;

  modport source (output valid, mode, az_in, el_in, ref_az, input ready);
  modport sink   (input valid, mode, az_in, el_in, ref_az, output ready);
endinterface

interface cwa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cwa_pkg::AZ_W-1:0]   unwrapped_az;
  logic                              secure;
  logic                              inside_res;

  modport source (output valid, unwrapped_az, secure, inside_res, input ready);
  modport sink   (input valid, unwrapped_az, secure, inside_res, output ready);
endinterface

// ----- rtl/cwa_step_unit.sv -----
// shared turn step unit: proposes the next candidate and decides whether to take it
// depends on cwa_pkg
module cwa_step_unit (
  input  cwa_pkg::az_t              cur,
  input  cwa_pkg::az_t              hi,
  input  cwa_pkg::az2_t             ref2,
  input  logic [cwa_pkg::K_W-1:0]   k,
  output cwa_pkg::step_res_t        res
);

  cwa_pkg::az_t  cand;
  cwa_pkg::az2_t d0;
  cwa_pkg::az2_t d1;
  cwa_pkg::az2_t m0;
  cwa_pkg::az2_t m1;

  // doubled distances to the reference, ties move up
  always_comb begin
    cand    = cur + cwa_pkg::TURN;
    d0      = (cwa_pkg::az2_t'(cur) <<< 1) - ref2;
    d1      = (cwa_pkg::az2_t'(cand) <<< 1) - ref2;
    m0      = d0[cwa_pkg::DW-1] ? -d0 : d0;
    m1      = d1[cwa_pkg::DW-1] ? -d1 : d1;
    res.adv = (k < cwa_pkg::MAX_K) && (cand <= hi) && !(m0 < m1);
    res.cand = cand;
  end

endmodule

// ----- rtl/cwa_limit_chk.sv -----
// limit check and secure margin test of the azimuth unwrapper
// depends on cwa_pkg
module cwa_limit_chk (
  input  cwa_pkg::az_t                     lo,
  input  cwa_pkg::az_t                     hi,
  input  cwa_pkg::az_t                     cur,
  input  logic [cwa_pkg::AZI_W-1:0]        az_in,
  input  logic signed [cwa_pkg::EL_W-1:0]  el_in,
  input  cwa_pkg::eb_t                     elo,
  input  cwa_pkg::eb_t                     ehi,
  output cwa_pkg::chk_res_t                res
);

  cwa_pkg::az_t  span;
  cwa_pkg::az_t  lo_low;
  cwa_pkg::az_t  hi_low;
  cwa_pkg::az_t  lo_rem;
  cwa_pkg::az_t  hi_rem;
  cwa_pkg::az_t  az_ext;
  cwa_pkg::eb_t  el_ext;
  cwa_pkg::az_t  gap_lo;
  cwa_pkg::az_t  gap_hi;
  cwa_pkg::prod_t p_lo;
  cwa_pkg::prod_t p_hi;
  logic          el_ok;
  logic          az_ok;

  // truncated remainders of the limits, sign follows the limit
  always_comb begin
    span   = hi - lo;
    lo_low = {{(cwa_pkg::CUR_W - cwa_pkg::TURN_BITS){1'b0}}, lo[cwa_pkg::TURN_BITS-1:0]};
    hi_low = {{(cwa_pkg::CUR_W - cwa_pkg::TURN_BITS){1'b0}}, hi[cwa_pkg::TURN_BITS-1:0]};
    lo_rem = (lo[cwa_pkg::CUR_W-1] && (lo_low != '0)) ? lo_low - cwa_pkg::TURN : lo_low;
    hi_rem = (hi[cwa_pkg::CUR_W-1] && (hi_low != '0)) ? hi_low - cwa_pkg::TURN : hi_low;
    az_ext = {{(cwa_pkg::CUR_W - cwa_pkg::AZI_W){1'b0}}, az_in};
    el_ext = cwa_pkg::eb_t'(el_in);
    el_ok  = (el_ext >= elo) && (el_ext <= ehi);
    az_ok  = (span >= cwa_pkg::TURN) || ((az_ext >= lo_rem) && (az_ext <= hi_rem));
    res.in_lim = el_ok && az_ok;
  end

  // more than three degrees inside both limits: gap * 120 > turn
  always_comb begin
    gap_lo = cur - lo;
    gap_hi = hi - cur;
    p_lo   = cwa_pkg::prod_t'(gap_lo) * cwa_pkg::prod_t'(cwa_pkg::SEC_MUL);
    p_hi   = cwa_pkg::prod_t'(gap_hi) * cwa_pkg::prod_t'(cwa_pkg::SEC_MUL);
    res.secure = (p_lo > cwa_pkg::prod_t'(cwa_pkg::TURN))
              && (p_hi > cwa_pkg::prod_t'(cwa_pkg::TURN));
  end

endmodule

// ----- rtl/cable_wrap_azimuth_unwrap.sv -----
// cable wrap azimuth unwrapper: a request goes from the reduce state through the step state
// (one step-unit decision per added turn plus the stopping one) to the finish state
// a new request is taken only in idle, once the last result is loaded into the output register
// a finished result may wait in the output register while the next request is worked on
// reset: synchronous, active low; config, state, valid get documented values; no clearing pass
// depends on cwa_pkg, cwa_if, cwa_step_unit, cwa_limit_chk and the assertion header
`include "cable_wrap_azimuth_unwrap_assert.svh"

module cable_wrap_azimuth_unwrap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cwa_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [cwa_pkg::CFG_W-1:0]         cfg_wdata,
  cwa_in_if.sink                            in_ch,
  cwa_out_if.source                         out_ch
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REDUCE = 4'b0010,
    S_STEP   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  // configuration registers
  logic signed [cwa_pkg::AZ_W-1:0]  az_lo_lim_r;
  logic signed [cwa_pkg::AZ_W-1:0]  az_hi_lim_r;
  logic [cwa_pkg::AZM_W-1:0]        az_lo_mrg_r;
  logic [cwa_pkg::AZM_W-1:0]        az_hi_mrg_r;
  logic signed [cwa_pkg::EL_W-1:0]  el_lo_lim_r;
  logic signed [cwa_pkg::EL_W-1:0]  el_hi_lim_r;
  logic [cwa_pkg::ELM_W-1:0]        el_lo_mrg_r;
  logic [cwa_pkg::ELM_W-1:0]        el_hi_mrg_r;

  // derived limits
  cwa_pkg::az_t   lo;
  cwa_pkg::az_t   hi;
  cwa_pkg::az2_t  nt2;
  cwa_pkg::eb_t   elo;
  cwa_pkg::eb_t   ehi;

  // request hold and working registers
  logic                              mode_r;
  logic [cwa_pkg::AZI_W-1:0]         az_r;
  logic signed [cwa_pkg::EL_W-1:0]   el_r;
  logic signed [cwa_pkg::AZ_W-1:0]   refaz_r;
  cwa_pkg::az_t                      cur_r,  cur_nxt;
  cwa_pkg::az2_t                     ref2_r, ref2_nxt;
  logic [cwa_pkg::K_W-1:0]           k_r,    k_nxt;
  logic                              inside_r, inside_nxt;
  state_t                            state_r, state_nxt;

  // output register
  logic                              out_valid_r;
  logic signed [cwa_pkg::AZ_W-1:0]   out_az_r;
  logic                              out_sec_r;
  logic                              out_ins_r;

  cwa_pkg::az_t                      diff;
  cwa_pkg::az_t                      sat;
  logic                              in_acc;
  logic                              fin_load;
  cwa_pkg::step_res_t                step;
  cwa_pkg::chk_res_t                 chk;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign fin_load = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.unwrapped_az = out_az_r;
  assign out_ch.secure       = out_sec_r;
  assign out_ch.inside_res   = out_ins_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_lo_lim_r <= cwa_pkg::AZ_LO_LIM_RST;
      az_hi_lim_r <= cwa_pkg::AZ_HI_LIM_RST;
      az_lo_mrg_r <= cwa_pkg::AZ_MRG_RST;
      az_hi_mrg_r <= cwa_pkg::AZ_MRG_RST;
      el_lo_lim_r <= cwa_pkg::EL_LO_LIM_RST;
      el_hi_lim_r <= cwa_pkg::EL_HI_LIM_RST;
      el_lo_mrg_r <= cwa_pkg::EL_MRG_RST;
      el_hi_mrg_r <= cwa_pkg::EL_MRG_RST;
    end else if (cfg_we) begin
      case (cwa_pkg::cfg_reg_t'(cfg_idx))
        cwa_pkg::REG_AZ_LO_LIM: az_lo_lim_r <= $signed(cfg_wdata[cwa_pkg::AZ_W-1:0]);
        cwa_pkg::REG_AZ_HI_LIM: az_hi_lim_r <= $signed(cfg_wdata[cwa_pkg::AZ_W-1:0]);
        cwa_pkg::REG_AZ_LO_MRG: az_lo_mrg_r <= cfg_wdata[cwa_pkg::AZM_W-1:0];
        cwa_pkg::REG_AZ_HI_MRG: az_hi_mrg_r <= cfg_wdata[cwa_pkg::AZM_W-1:0];
        cwa_pkg::REG_EL_LO_LIM: el_lo_lim_r <= $signed(cfg_wdata[cwa_pkg::EL_W-1:0]);
        cwa_pkg::REG_EL_HI_LIM: el_hi_lim_r <= $signed(cfg_wdata[cwa_pkg::EL_W-1:0]);
        cwa_pkg::REG_EL_LO_MRG: el_lo_mrg_r <= cfg_wdata[cwa_pkg::ELM_W-1:0];
        cwa_pkg::REG_EL_HI_MRG: el_hi_mrg_r <= cfg_wdata[cwa_pkg::ELM_W-1:0];
        default: ;
      endcase
    end
  end

  // offset limits, doubled neutral point and elevation bounds
  always_comb begin
    lo  = cwa_pkg::az_t'(az_lo_lim_r) + cwa_pkg::az_t'($signed({1'b0, az_lo_mrg_r}));
    hi  = cwa_pkg::az_t'(az_hi_lim_r) - cwa_pkg::az_t'($signed({1'b0, az_hi_mrg_r}));
    nt2 = cwa_pkg::az2_t'(az_lo_lim_r) + cwa_pkg::az2_t'(az_hi_lim_r);
    elo = cwa_pkg::eb_t'(el_lo_lim_r) + cwa_pkg::eb_t'($signed({1'b0, el_lo_mrg_r}));
    ehi = cwa_pkg::eb_t'(el_hi_lim_r) - cwa_pkg::eb_t'($signed({1'b0, el_hi_mrg_r}));
  end

  // shared step unit and limit check
  cwa_step_unit u_step (
    .cur  (cur_r),
    .hi   (hi),
    .ref2 (ref2_r),
    .k    (k_r),
    .res  (step)
  );

  cwa_limit_chk u_chk (
    .lo    (lo),
    .hi    (hi),
    .cur   (cur_r),
    .az_in (az_r),
    .el_in (el_r),
    .elo   (elo),
    .ehi   (ehi),
    .res   (chk)
  );

  // sequencer: reduce, step by turns, finish
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    ref2_nxt   = ref2_r;
    k_nxt      = k_r;
    inside_nxt = inside_r;
    diff       = {{(cwa_pkg::CUR_W - cwa_pkg::AZI_W){1'b0}}, az_r} - lo;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        cur_nxt    = lo + cwa_pkg::az_t'($signed({1'b0, diff[cwa_pkg::TURN_BITS-1:0]}));
        ref2_nxt   = mode_r ? (cwa_pkg::az2_t'(refaz_r) <<< 1) : nt2;
        k_nxt      = '0;
        inside_nxt = chk.in_lim;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        if (step.adv) begin
          cur_nxt = step.cand;
          k_nxt   = k_r + 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture and working values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_ch.mode;
      az_r    <= in_ch.az_in;
      el_r    <= in_ch.el_in;
      refaz_r <= in_ch.ref_az;
    end
    cur_r    <= cur_nxt;
    ref2_r   <= ref2_nxt;
    k_r      <= k_nxt;
    inside_r <= inside_nxt;
  end

  // saturate to the result range
  always_comb begin
    if (cur_r > cwa_pkg::OUT_MAX) begin
      sat = cwa_pkg::OUT_MAX;
    end else if (cur_r < cwa_pkg::OUT_MIN) begin
      sat = cwa_pkg::OUT_MIN;
    end else begin
      sat = cur_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_az_r  <= $signed(sat[cwa_pkg::AZ_W-1:0]);
      out_sec_r <= chk.secure;
      out_ins_r <= inside_r;
    end
  end

  // checks on the sequencer
  `CWA_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `CWA_ASSERT_NXT(a_accept_reduce, clk, rst_n, in_ch.valid && in_ch.ready, state_r == S_REDUCE)
  `CWA_ASSERT_IMP(a_wrap_bound, clk, rst_n, state_r == S_STEP, k_r <= cwa_pkg::MAX_K)
  `CWA_ASSERT_IMP(a_valid_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FINISH)

endmodule

// ----- tb/sv/cable_wrap_azimuth_unwrap_test.sv -----
// self-checking testbench for the cable wrap azimuth unwrapper: directed and random pointing
// requests over several limit settings, each result checked against a built-in predictor
// depends on cwa_pkg, cwa_if and the cable_wrap_azimuth_unwrap rtl
module cable_wrap_azimuth_unwrap_test;

  // package constants used throughout
  localparam int TURN_BITS = cwa_pkg::TURN_BITS;
  localparam int MAX_WRAPS = cwa_pkg::MAX_WRAPS;
  localparam int AZ_W      = cwa_pkg::AZ_W;
  localparam int AZI_W     = cwa_pkg::AZI_W;
  localparam int EL_W      = cwa_pkg::EL_W;
  localparam int AZM_W     = cwa_pkg::AZM_W;
  localparam int ELM_W     = cwa_pkg::ELM_W;
  localparam int CFG_W     = cwa_pkg::CFG_W;
  localparam int CFG_IDX_W = cwa_pkg::CFG_IDX_W;

  localparam longint TURN_L       = longint'(1) << TURN_BITS;
  localparam longint AZ_TOP       = (longint'(1) << (AZ_W - 1)) - 1;
  localparam longint AZ_BOT       = -(longint'(1) << (AZ_W - 1));
  localparam int     SETTLE_CYCLES = 2 * (4 + MAX_WRAPS);
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     RAND_PER_SET = 175;

  // limit registers as held by the block
  typedef struct {
    logic signed [AZ_W-1:0] az_lo_lim;
    logic signed [AZ_W-1:0] az_hi_lim;
    logic [AZM_W-1:0]       az_lo_mrg;
    logic [AZM_W-1:0]       az_hi_mrg;
    logic signed [EL_W-1:0] el_lo_lim;
    logic signed [EL_W-1:0] el_hi_lim;
    logic [ELM_W-1:0]       el_lo_mrg;
    logic [ELM_W-1:0]       el_hi_mrg;
  } limits_t;

  typedef struct {
    logic                   mode;
    logic [AZI_W-1:0]       az;
    logic signed [EL_W-1:0] el;
    logic signed [AZ_W-1:0] refaz;
  } pointing_req_t;

  typedef struct {
    logic signed [AZ_W-1:0] az;
    logic                   secure;
    logic                   in_lim;
  } pointing_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  cwa_in_if  in_ch();
  cwa_out_if out_ch();

  limits_t       limits;
  pointing_req_t req_q[$];
  pointing_t     pointing_q[$];

  int   n_queued   = 0;
  int   n_sent     = 0;
  int   n_accepted = 0;
  int   n_checked  = 0;
  int   n_secure   = 0;
  int   n_inside   = 0;
  int   n_settings = 1;
  int   fails      = 0;
  int   send_pct   = 0;
  int   recv_pct   = 0;
  int   send_gap   = 0;
  int   recv_gap   = 0;
  int   cycle_cnt  = 0;

  cable_wrap_azimuth_unwrap i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // known values on every input from time zero
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.mode    = 1'b0;
    in_ch.az_in   = '0;
    in_ch.el_in   = '0;
    in_ch.ref_az  = '0;
    out_ch.ready  = 1'b0;
  end

  // expected pointing for one request under the current limits
  function automatic pointing_t predict_pointing(pointing_req_t q);
    longint    az, el, rf, lo, hi, ref2, r, cur, cand, diff, steps, k, d0, d1, elo, ehi;
    logic      ok;
    pointing_t p;
    az   = longint'(q.az);
    el   = longint'(q.el);
    rf   = longint'(q.refaz);
    lo   = longint'(limits.az_lo_lim) + longint'(limits.az_lo_mrg);
    hi   = longint'(limits.az_hi_lim) - longint'(limits.az_hi_mrg);
    ref2 = q.mode ? 2 * rf : longint'(limits.az_lo_lim) + longint'(limits.az_hi_lim);

    // reduce into the first turn above the offset lower limit
    r = (az - lo) % TURN_L;
    if (r < 0) r = r + TURN_L;
    cur = lo + r;

    // whole turns that fit under the offset upper limit
    diff  = hi - cur;
    steps = (diff < 0) ? 0 : diff / TURN_L;
    if (steps > MAX_WRAPS) steps = MAX_WRAPS;

    // climb while the next turn is no further from the reference
    for (k = 1; k <= steps; k++) begin
      cand = cur + TURN_L;
      d0 = 2 * cur - ref2;
      d1 = 2 * cand - ref2;
      if (d0 < 0) d0 = -d0;
      if (d1 < 0) d1 = -d1;
      if (d0 < d1) break;
      cur = cand;
    end

    p.secure = ((cur - lo) * 360 > 3 * TURN_L) && ((hi - cur) * 360 > 3 * TURN_L);

    // limit check on the raw request, truncated remainders
    elo = longint'(limits.el_lo_lim) + longint'(limits.el_lo_mrg);
    ehi = longint'(limits.el_hi_lim) - longint'(limits.el_hi_mrg);
    ok  = 1'b1;
    if (el < elo || el > ehi) ok = 1'b0;
    if (hi - lo < TURN_L) begin
      if (az < lo % TURN_L || az > hi % TURN_L) ok = 1'b0;
    end
    p.in_lim = ok;

    if (cur > AZ_TOP) cur = AZ_TOP;
    if (cur < AZ_BOT) cur = AZ_BOT;
    p.az = AZ_W'(cur);
    return p;
  endfunction

  // request source, fed from req_q
  always @(negedge clk) begin
    pointing_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && n_accepted != n_sent) begin
      // request still waiting for ready
    end else begin
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        n_sent       <= n_sent + 1;
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= nxt.mode;
        in_ch.az_in  <= nxt.az;
        in_ch.el_in  <= nxt.el;
        in_ch.ref_az <= nxt.refaz;
        if (send_pct != 0 && $urandom_range(99) < send_pct) send_gap <= $urandom_range(15, 1);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random stall bursts
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= recv_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (recv_pct != 0 && $urandom_range(99) < recv_pct) recv_gap <= $urandom_range(15, 1);
    end
  end

  // monitor: check results, predict accepted requests
  always @(posedge clk) begin
    pointing_t     want;
    pointing_req_t got_req;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pointing_q.size() == 0) begin
          $error("unexpected result: unwrapped_az %0d with no request outstanding",
                 out_ch.unwrapped_az);
          fails++;
        end else begin
          want = pointing_q.pop_front();
          if (out_ch.unwrapped_az !== want.az) begin
            $error("unwrapped_az: expected %0d, got %0d", want.az, out_ch.unwrapped_az);
            fails++;
          end
          if (out_ch.secure !== want.secure) begin
            $error("secure: expected %0b, got %0b", want.secure, out_ch.secure);
            fails++;
          end
          if (out_ch.inside_res !== want.in_lim) begin
            $error("inside_res: expected %0b, got %0b", want.in_lim, out_ch.inside_res);
            fails++;
          end
          if (want.secure) n_secure++;
          if (want.in_lim) n_inside++;
          n_checked <= n_checked + 1;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got_req.mode  = in_ch.mode;
        got_req.az    = in_ch.az_in;
        got_req.el    = in_ch.el_in;
        got_req.refaz = in_ch.ref_az;
        pointing_q.push_back(predict_pointing(got_req));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("status: fail");
    $finish;
  end

  task automatic add_req(input logic m, input logic [AZI_W-1:0] az,
                         input logic signed [EL_W-1:0] el, input logic signed [AZ_W-1:0] rf);
    pointing_req_t q;
    q.mode  = m;
    q.az    = az;
    q.el    = el;
    q.refaz = rf;
    req_q.push_back(q);
    n_queued++;
  endtask

  // wait until every queued request is accepted and has its result, then let the block go quiet
  task automatic settle();
    do @(negedge clk); while (!(n_accepted == n_queued && n_checked == n_accepted));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cwa_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  task automatic apply_limits(input limits_t nl);
    limits = nl;
    write_reg(cwa_pkg::REG_AZ_LO_LIM, CFG_W'(nl.az_lo_lim));
    write_reg(cwa_pkg::REG_AZ_HI_LIM, CFG_W'(nl.az_hi_lim));
    write_reg(cwa_pkg::REG_AZ_LO_MRG, CFG_W'(nl.az_lo_mrg));
    write_reg(cwa_pkg::REG_AZ_HI_MRG, CFG_W'(nl.az_hi_mrg));
    write_reg(cwa_pkg::REG_EL_LO_LIM, CFG_W'(nl.el_lo_lim));
    write_reg(cwa_pkg::REG_EL_HI_LIM, CFG_W'(nl.el_hi_lim));
    write_reg(cwa_pkg::REG_EL_LO_MRG, CFG_W'(nl.el_lo_mrg));
    write_reg(cwa_pkg::REG_EL_HI_MRG, CFG_W'(nl.el_hi_mrg));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic limits_t make_limits(input longint alo, input longint ahi,
                                          input longint almg, input longint ahmg,
                                          input longint elo, input longint ehi,
                                          input longint elmg, input longint ehmg);
    limits_t nl;
    nl.az_lo_lim = AZ_W'(alo);
    nl.az_hi_lim = AZ_W'(ahi);
    nl.az_lo_mrg = AZM_W'(almg);
    nl.az_hi_mrg = AZM_W'(ahmg);
    nl.el_lo_lim = EL_W'(elo);
    nl.el_hi_lim = EL_W'(ehi);
    nl.el_lo_mrg = ELM_W'(elmg);
    nl.el_hi_mrg = ELM_W'(ehmg);
    return nl;
  endfunction

  // either a plausible wrap range or raw register bit patterns
  function automatic limits_t random_limits();
    if ($urandom_range(1))
      return make_limits(-longint'($urandom_range(131072)), longint'($urandom_range(131071)),
                         longint'($urandom_range(8192)), longint'($urandom_range(8192)),
                         -longint'($urandom_range(16384)), longint'($urandom_range(16384)),
                         longint'($urandom_range(2048)), longint'($urandom_range(2048)));
    return make_limits(longint'($urandom), longint'($urandom), longint'($urandom),
                       longint'($urandom), longint'($urandom), longint'($urandom),
                       longint'($urandom), longint'($urandom));
  endfunction

  // random request biased to limit edges and to reference ties
  task automatic add_random_req();
    longint lo, hi, elo, ehi, az, el, rf;
    lo  = longint'(limits.az_lo_lim) + longint'(limits.az_lo_mrg);
    hi  = longint'(limits.az_hi_lim) - longint'(limits.az_hi_mrg);
    elo = longint'(limits.el_lo_lim) + longint'(limits.el_lo_mrg);
    ehi = longint'(limits.el_hi_lim) - longint'(limits.el_hi_mrg);
    case ($urandom_range(3))
      1:       az = lo + longint'($urandom_range(4)) - 2;
      2:       az = hi + longint'($urandom_range(4)) - 2;
      default: az = longint'($urandom_range(65535));
    endcase
    case ($urandom_range(3))
      1:       el = elo + longint'($urandom_range(2)) - 1;
      2:       el = ehi + longint'($urandom_range(2)) - 1;
      default: el = longint'($urandom_range(32768)) - 16384;
    endcase
    if (el > 16384) el = 16384;
    if (el < -16384) el = -16384;
    case ($urandom_range(2))
      0:       rf = longint'($urandom);
      1:       rf = longint'(AZI_W'(az)) + TURN_L / 2 + TURN_L * longint'($urandom_range(3))
                    + longint'($urandom_range(2)) - 1;
      default: rf = lo + longint'($urandom_range(4 * 65536));
    endcase
    add_req(1'($urandom_range(1)), AZI_W'(az), EL_W'(el), AZ_W'(rf));
  endtask

  // one limit setting: drain, write, then a batch of random requests
  task automatic run_setting(input limits_t nl, input int s_pct, input int r_pct);
    settle();
    apply_limits(nl);
    @(posedge clk);
    send_pct = s_pct;
    recv_pct = r_pct;
    repeat (RAND_PER_SET) add_random_req();
  endtask

  // main sequence
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = cwa_pkg::REG_AZ_LO_LIM;
    cfg_wdata = '0;
    limits = make_limits(cwa_pkg::AZ_LO_LIM_RST, cwa_pkg::AZ_HI_LIM_RST,
                         cwa_pkg::AZ_MRG_RST, cwa_pkg::AZ_MRG_RST,
                         cwa_pkg::EL_LO_LIM_RST, cwa_pkg::EL_HI_LIM_RST,
                         cwa_pkg::EL_MRG_RST, cwa_pkg::EL_MRG_RST);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests under the reset limits
    @(posedge clk);
    send_pct = 20;
    recv_pct = 5;
    add_req(1'b0, 16'd0, 16'sd0, 18'sd0);
    add_req(1'b0, 16'd65535, 16'sd16384, -18'sd131072);
    add_req(1'b1, 16'd32768, -16'sd16384, 18'sd131071);
    // tie between two turns moves up, one unit less stays
    add_req(1'b1, 16'd49152, 16'sd1, 18'sd16384);
    add_req(1'b1, 16'd49152, 16'sd1, 18'sd16383);
    // three degree edge above the lower limit
    add_req(1'b1, 16'd16930, 16'sd100, -18'sd131072);
    add_req(1'b1, 16'd16931, 16'sd100, -18'sd131072);
    // three degree edge below the upper limit
    add_req(1'b1, 16'd48606, 16'sd200, 18'sd131071);
    add_req(1'b1, 16'd48605, 16'sd200, 18'sd131071);
    // wrapped azimuth on the lower limit and one below
    add_req(1'b0, 16'd16384, -16'sd1, 18'sd0);
    add_req(1'b0, 16'd16383, 16'sd16383, 18'sd0);
    add_req(1'b0, 16'hAAAA, 16'sd0, 18'h2AAAA);
    add_req(1'b1, 16'h5555, 16'sd16384, 18'h15555);
    add_req(1'b1, 16'd0, -16'sd1, 18'h1FFFF);

    // narrow range with margins, negative lower remainder
    run_setting(make_limits(-10000, 20000, 100, 200, -5000, 8000, 10, 20), 20, 5);
    // widest raw range, no margins
    run_setting(make_limits(-131072, 131071, 0, 0, -16384, 16384, 0, 0), 0, 8);
    // crossed limits with largest azimuth margins, saturating result
    run_setting(make_limits(131071, -131072, 65535, 65535, 16384, -16384, 16384, 16384),
                30, 0);
    // widest range shrunk by largest azimuth margins
    run_setting(make_limits(-131072, 131071, 65535, 65535, -16384, 16384, 16384, 0), 10, 3);
    // narrow range entirely below zero
    run_setting(make_limits(-100000, -90000, 0, 0, -16384, -100, 0, 16384), 20, 5);
    repeat (3) run_setting(random_limits(), $urandom_range(40), $urandom_range(10));
    // back to reset values, no idling at either side
    run_setting(make_limits(cwa_pkg::AZ_LO_LIM_RST, cwa_pkg::AZ_HI_LIM_RST,
                            cwa_pkg::AZ_MRG_RST, cwa_pkg::AZ_MRG_RST,
                            cwa_pkg::EL_LO_LIM_RST, cwa_pkg::EL_HI_LIM_RST,
                            cwa_pkg::EL_MRG_RST, cwa_pkg::EL_MRG_RST), 0, 0);
    settle();

    if (pointing_q.size() != 0) begin
      $error("%0d expected results never arrived", pointing_q.size());
    end
    $display("checked %0d of %0d pointing requests over %0d limit settings",
             n_checked, n_queued, n_settings);
    $display("%0d results secure, %0d inside the offset limits", n_secure, n_inside);
    if (fails == 0 && pointing_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fails);
      $display("status: fail");
    end
    $finish;
  end

endmodule
